### rtl/gsr_pkg.sv
package gsr_pkg;

    // Operation codes of the input word
    typedef enum logic [3:0] {
        OP_CREATE     = 4'd0,
        OP_RESOLVE    = 4'd1,
        OP_ACTIVATE   = 4'd2,
        OP_RETIRE     = 4'd3,
        OP_RECLAIM    = 4'd4,
        OP_QUARANTINE = 4'd5,
        OP_ROLLBACK   = 4'd6,
        OP_QUAR_SLOT  = 4'd7,
        OP_DESTROY    = 4'd8,
        OP_FADE_BEGIN = 4'd9,
        OP_FADE_END   = 4'd10,
        OP_QUERY      = 4'd11
    } op_t;

    // Per-slot lifecycle codes
    typedef enum logic [2:0] {
        LC_RECLAIMED      = 3'd0,
        LC_CONSTRUCTING   = 3'd1,
        LC_ACTIVE         = 3'd2,
        LC_FADING_OUT     = 3'd3,
        LC_FADING_IN      = 3'd4,
        LC_RETIRED        = 3'd5,
        LC_QUARANTINED    = 3'd6,
        LC_DESTROY_PEND   = 3'd7
    } lc_t;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ISSUE,
        ST_POP,
        ST_EXEC,
        ST_WR2
    } state_t;

    // Classified input word carried from front to back
    typedef struct packed {
        op_t         op;
        logic        live_hs;
        logic        hs_in_range;
        logic        live_os;
        logic [7:0]  hs;
        logic [31:0] hg;
        logic [7:0]  os;
        logic [31:0] og;
        logic [31:0] fid;
        logic [31:0] tag;
    } item_t;

endpackage

### rtl/gsr_front.sv
module gsr_front #(
    parameter int SLOTS = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [3:0]           s_op,
    input  logic [7:0]           s_handle_slot,
    input  logic [31:0]          s_handle_generation,
    input  logic [7:0]           s_other_slot,
    input  logic [31:0]          s_other_generation,
    input  logic [31:0]          s_fade_id,
    input  logic [31:0]          s_instance_tag,
    output logic                 q_valid,
    output gsr_pkg::item_t       q_item,
    input  logic                 q_pop
);

    gsr_pkg::item_t in_item;
    gsr_pkg::item_t entry_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic           push;

    // Classify the incoming word
    always_comb begin
        in_item.op          = gsr_pkg::op_t'(s_op);
        in_item.hs_in_range = (32'(s_handle_slot) < 32'(SLOTS));
        in_item.live_hs     = in_item.hs_in_range && (s_handle_slot != 8'd0);
        in_item.live_os     = (32'(s_other_slot) < 32'(SLOTS)) && (s_other_slot != 8'd0);
        in_item.hs          = s_handle_slot;
        in_item.hg          = s_handle_generation;
        in_item.os          = s_other_slot;
        in_item.og          = s_other_generation;
        in_item.fid         = s_fade_id;
        in_item.tag         = s_instance_tag;
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = entry_reg[rd_ptr_reg];

    // Advance queue pointers
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Hold queued words
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

### rtl/gsr_exec.sv
module gsr_exec #(
    parameter int SLOTS = 256,
    parameter int FADES = 8
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    input  gsr_pkg::item_t  q_item,
    output logic            q_pop,
    output logic            m_valid,
    input  logic            m_ready,
    output logic            m_done_res,
    output logic [7:0]      m_out_slot,
    output logic [31:0]     m_out_generation,
    output logic [31:0]     m_instance_out,
    output logic            m_resolved_valid,
    output logic            m_stale,
    output logic            m_table_full,
    output logic [7:0]      m_active_slot,
    output logic [31:0]     m_active_generation,
    output logic [7:0]      m_fading_slot,
    output logic [31:0]     m_fading_generation
);

    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int FW = (FADES > 1) ? $clog2(FADES) : 1;

    gsr_pkg::state_t state_reg, state_next;
    gsr_pkg::item_t  cur_reg;
    logic [SW-1:0]   clr_reg;
    logic [CW-1:0]   count_reg;

    // Slot table and free stack
    logic [31:0]       gen_mem [SLOTS];
    logic [31:0]       tag_mem [SLOTS];
    gsr_pkg::lc_t      lc_mem  [SLOTS];
    logic [SW-1:0]     stk_mem [SLOTS];
    logic [31:0]       gen_rd_reg;
    logic [31:0]       tag_rd_reg;
    gsr_pkg::lc_t      lc_rd_reg;
    logic [SW-1:0]     stk_rd_reg;

    // Crossfade records
    logic              fade_valid_reg [FADES];
    logic [31:0]       fade_id_reg    [FADES];
    logic [7:0]        fade_from_reg  [FADES];
    logic [7:0]        fade_to_s_reg  [FADES];
    logic [31:0]       fade_to_g_reg  [FADES];
    logic [FADES-1:0]  hit_reg, idm_reg, free_reg;
    logic [FADES-1:0]  hit_vec, idm_vec, free_vec;

    logic [7:0]  act_s_reg, act_s_next;
    logic [31:0] act_g_reg, act_g_next;
    logic [7:0]  fad_s_reg, fad_s_next;
    logic [31:0] fad_g_reg, fad_g_next;

    logic [SW-1:0]   wr2_addr_reg;
    gsr_pkg::lc_t    wr2_lc_reg;
    logic            wr2_en;
    logic [SW-1:0]   wr2_addr;
    gsr_pkg::lc_t    wr2_lc;

    // Memory port controls
    logic [SW-1:0]   rd_addr;
    logic [SW-1:0]   wr_addr;
    logic            gen_we, tag_we, lc_we;
    logic [31:0]     gen_wd, tag_wd;
    gsr_pkg::lc_t    lc_wd;
    logic            stk_we;
    logic [SW-1:0]   stk_wa, stk_wd;
    logic            stk_re;
    logic            push_en, pop_en;
    logic            fade_set, fade_clr;
    logic [FW-1:0]   free_idx, idm_idx;
    logic            in_fade;

    // Result word
    logic        r_done, r_valid, r_stale, r_full;
    logic [7:0]  r_slot;
    logic [31:0] r_gen, r_inst;
    logic        out_valid_reg;
    logic        out_done_reg, out_rvalid_reg, out_stale_reg, out_full_reg;
    logic [7:0]  out_slot_reg, out_act_s_reg, out_fad_s_reg;
    logic [31:0] out_gen_reg, out_inst_reg, out_act_g_reg, out_fad_g_reg;

    // Index conversions
    logic [SW+7:0] hs_wide, os_wide, s_wide, fs_wide, ts_wide, clr_wide;
    logic [SW-1:0] hs_idx, os_idx, fs_idx, ts_idx;
    logic [CW-1:0] cnt_m1;
    logic          cnt_room;

    assign hs_wide  = {{SW{1'b0}}, cur_reg.hs};
    assign os_wide  = {{SW{1'b0}}, cur_reg.os};
    assign fs_wide  = {{SW{1'b0}}, fade_from_reg[idm_idx]};
    assign ts_wide  = {{SW{1'b0}}, fade_to_s_reg[idm_idx]};
    assign s_wide   = {8'd0, stk_rd_reg};
    assign clr_wide = {8'd0, clr_reg} + 1'b1;
    assign hs_idx   = hs_wide[SW-1:0];
    assign os_idx   = os_wide[SW-1:0];
    assign fs_idx   = fs_wide[SW-1:0];
    assign ts_idx   = ts_wide[SW-1:0];
    assign cnt_m1   = count_reg - 1'b1;
    assign cnt_room = (32'(count_reg) < 32'(SLOTS));

    assign q_pop = (state_reg == gsr_pkg::ST_IDLE) && q_valid && !out_valid_reg;

    // Match the fade records against the current word
    always_comb begin
        for (int i = 0; i < FADES; i++) begin
            hit_vec[i]  = fade_valid_reg[i] && ((fade_from_reg[i] == cur_reg.hs) ||
                                                (fade_to_s_reg[i] == cur_reg.hs));
            idm_vec[i]  = fade_valid_reg[i] && (fade_id_reg[i] == cur_reg.fid);
            free_vec[i] = !fade_valid_reg[i];
        end
    end

    // Pick lowest free and lowest matching record
    always_comb begin
        free_idx = '0;
        idm_idx  = '0;
        for (int i = FADES - 1; i >= 0; i--) begin
            if (free_reg[i]) begin
                free_idx = FW'(i);
            end
            if (idm_reg[i]) begin
                idm_idx = FW'(i);
            end
        end
        in_fade = |hit_reg;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            gsr_pkg::ST_CLEAR: begin
                if (32'(clr_reg) == 32'(SLOTS - 1)) begin
                    state_next = gsr_pkg::ST_IDLE;
                end
            end
            gsr_pkg::ST_IDLE: begin
                if (q_pop) begin
                    state_next = gsr_pkg::ST_ISSUE;
                end
            end
            gsr_pkg::ST_ISSUE: begin
                state_next = (cur_reg.op == gsr_pkg::OP_CREATE) ? gsr_pkg::ST_POP
                                                                : gsr_pkg::ST_EXEC;
            end
            gsr_pkg::ST_POP:  state_next = gsr_pkg::ST_EXEC;
            gsr_pkg::ST_EXEC: state_next = wr2_en ? gsr_pkg::ST_WR2 : gsr_pkg::ST_IDLE;
            gsr_pkg::ST_WR2:  state_next = gsr_pkg::ST_IDLE;
            default:          state_next = gsr_pkg::ST_IDLE;
        endcase
    end

    // Datapath controls and result for each state
    always_comb begin
        rd_addr    = hs_idx;
        stk_re     = 1'b0;
        wr_addr    = hs_idx;
        gen_we     = 1'b0;
        tag_we     = 1'b0;
        lc_we      = 1'b0;
        gen_wd     = gen_rd_reg + 32'd1;
        tag_wd     = cur_reg.tag;
        lc_wd      = gsr_pkg::LC_RECLAIMED;
        stk_we     = 1'b0;
        stk_wa     = count_reg[SW-1:0];
        stk_wd     = hs_idx;
        push_en    = 1'b0;
        pop_en     = 1'b0;
        fade_set   = 1'b0;
        fade_clr   = 1'b0;
        wr2_en     = 1'b0;
        wr2_addr   = os_idx;
        wr2_lc     = gsr_pkg::LC_FADING_IN;
        act_s_next = act_s_reg;
        act_g_next = act_g_reg;
        fad_s_next = fad_s_reg;
        fad_g_next = fad_g_reg;
        r_done     = 1'b0;
        r_valid    = 1'b0;
        r_stale    = 1'b0;
        r_full     = 1'b0;
        r_slot     = 8'd0;
        r_gen      = 32'd0;
        r_inst     = 32'd0;

        case (state_reg)
            gsr_pkg::ST_CLEAR: begin
                wr_addr = clr_reg;
                gen_we  = 1'b1;
                gen_wd  = 32'd0;
                tag_we  = 1'b1;
                tag_wd  = 32'd0;
                lc_we   = 1'b1;
                stk_we  = 1'b1;
                stk_wa  = clr_reg;
                stk_wd  = clr_wide[SW-1:0];
            end
            gsr_pkg::ST_ISSUE: begin
                stk_re = 1'b1;
            end
            gsr_pkg::ST_POP: begin
                rd_addr = stk_rd_reg;
            end
            gsr_pkg::ST_WR2: begin
                wr_addr = wr2_addr_reg;
                lc_we   = 1'b1;
                lc_wd   = wr2_lc_reg;
            end
            gsr_pkg::ST_EXEC: begin
                case (cur_reg.op)
                    gsr_pkg::OP_CREATE: begin
                        if (count_reg == '0) begin
                            r_full = 1'b1;
                        end else begin
                            pop_en  = 1'b1;
                            wr_addr = stk_rd_reg;
                            gen_we  = 1'b1;
                            tag_we  = 1'b1;
                            lc_we   = 1'b1;
                            lc_wd   = gsr_pkg::LC_CONSTRUCTING;
                            r_slot  = s_wide[7:0];
                            r_gen   = gen_rd_reg + 32'd1;
                            r_done  = 1'b1;
                        end
                    end
                    gsr_pkg::OP_RESOLVE: begin
                        if (cur_reg.live_hs) begin
                            if (gen_rd_reg != cur_reg.hg) begin
                                r_stale = 1'b1;
                            end else if (lc_rd_reg != gsr_pkg::LC_RECLAIMED &&
                                         lc_rd_reg != gsr_pkg::LC_QUARANTINED) begin
                                r_valid = 1'b1;
                                r_inst  = tag_rd_reg;
                            end
                        end
                    end
                    gsr_pkg::OP_ACTIVATE: begin
                        if (cur_reg.live_hs) begin
                            lc_we      = 1'b1;
                            lc_wd      = gsr_pkg::LC_ACTIVE;
                            act_s_next = cur_reg.hs;
                            act_g_next = cur_reg.hg;
                            fad_s_next = 8'd0;
                            fad_g_next = 32'd0;
                        end
                    end
                    gsr_pkg::OP_RETIRE: begin
                        lc_we = cur_reg.live_hs;
                        lc_wd = gsr_pkg::LC_RETIRED;
                    end
                    gsr_pkg::OP_QUARANTINE: begin
                        lc_we = cur_reg.live_hs;
                        lc_wd = gsr_pkg::LC_QUARANTINED;
                    end
                    gsr_pkg::OP_QUAR_SLOT: begin
                        lc_we = cur_reg.hs_in_range;
                        lc_wd = gsr_pkg::LC_QUARANTINED;
                    end
                    gsr_pkg::OP_RECLAIM: begin
                        if (cur_reg.live_hs && gen_rd_reg == cur_reg.hg &&
                            lc_rd_reg != gsr_pkg::LC_RECLAIMED) begin
                            lc_we   = 1'b1;
                            push_en = 1'b1;
                        end
                    end
                    gsr_pkg::OP_ROLLBACK: begin
                        if (cur_reg.live_hs && lc_rd_reg == gsr_pkg::LC_CONSTRUCTING) begin
                            lc_we   = 1'b1;
                            push_en = 1'b1;
                            r_done  = 1'b1;
                        end
                    end
                    gsr_pkg::OP_DESTROY: begin
                        if (cur_reg.hs_in_range &&
                            (cur_reg.hg == 32'd0 || gen_rd_reg == cur_reg.hg) &&
                            lc_rd_reg == gsr_pkg::LC_QUARANTINED &&
                            act_s_reg != cur_reg.hs && fad_s_reg != cur_reg.hs &&
                            !in_fade) begin
                            lc_we   = 1'b1;
                            push_en = cur_reg.live_hs;
                        end
                    end
                    gsr_pkg::OP_FADE_BEGIN: begin
                        if (cur_reg.live_hs && cur_reg.live_os) begin
                            if (free_reg == '0) begin
                                r_full = 1'b1;
                            end else begin
                                lc_we      = 1'b1;
                                lc_wd      = gsr_pkg::LC_FADING_OUT;
                                wr2_en     = 1'b1;
                                fade_set   = 1'b1;
                                fad_s_next = cur_reg.hs;
                                fad_g_next = cur_reg.hg;
                            end
                        end
                    end
                    gsr_pkg::OP_FADE_END: begin
                        if (idm_reg != '0) begin
                            fade_clr   = 1'b1;
                            wr_addr    = fs_idx;
                            lc_we      = 1'b1;
                            lc_wd      = gsr_pkg::LC_RETIRED;
                            wr2_en     = 1'b1;
                            wr2_addr   = ts_idx;
                            wr2_lc     = gsr_pkg::LC_ACTIVE;
                            act_s_next = fade_to_s_reg[idm_idx];
                            act_g_next = fade_to_g_reg[idm_idx];
                            fad_s_next = 8'd0;
                            fad_g_next = 32'd0;
                        end
                    end
                    gsr_pkg::OP_QUERY: begin
                        r_done = in_fade;
                    end
                    default: begin
                    end
                endcase
                // Push a freed slot unless the stack is full
                if (push_en && cnt_room) begin
                    stk_we = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= gsr_pkg::ST_CLEAR;
            clr_reg       <= '0;
            count_reg     <= CW'(SLOTS - 1);
            act_s_reg     <= 8'd0;
            act_g_reg     <= 32'd0;
            fad_s_reg     <= 8'd0;
            fad_g_reg     <= 32'd0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < FADES; i++) begin
                fade_valid_reg[i] <= 1'b0;
            end
        end else begin
            state_reg <= state_next;
            if (state_reg == gsr_pkg::ST_CLEAR) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (pop_en) begin
                count_reg <= cnt_m1;
            end else if (stk_we && state_reg == gsr_pkg::ST_EXEC) begin
                count_reg <= count_reg + 1'b1;
            end
            act_s_reg <= act_s_next;
            act_g_reg <= act_g_next;
            fad_s_reg <= fad_s_next;
            fad_g_reg <= fad_g_next;
            if (fade_set) begin
                fade_valid_reg[free_idx] <= 1'b1;
            end
            if (fade_clr) begin
                fade_valid_reg[idm_idx] <= 1'b0;
            end
            if (state_reg == gsr_pkg::ST_EXEC) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_item;
        end
        if (state_reg == gsr_pkg::ST_ISSUE) begin
            hit_reg  <= hit_vec;
            idm_reg  <= idm_vec;
            free_reg <= free_vec;
        end
        if (fade_set) begin
            fade_id_reg[free_idx]   <= cur_reg.fid;
            fade_from_reg[free_idx] <= cur_reg.hs;
            fade_to_s_reg[free_idx] <= cur_reg.os;
            fade_to_g_reg[free_idx] <= cur_reg.og;
        end
        if (wr2_en) begin
            wr2_addr_reg <= wr2_addr;
            wr2_lc_reg   <= wr2_lc;
        end
        if (state_reg == gsr_pkg::ST_EXEC) begin
            out_done_reg   <= r_done;
            out_slot_reg   <= r_slot;
            out_gen_reg    <= r_gen;
            out_inst_reg   <= r_inst;
            out_rvalid_reg <= r_valid;
            out_stale_reg  <= r_stale;
            out_full_reg   <= r_full;
            out_act_s_reg  <= act_s_next;
            out_act_g_reg  <= act_g_next;
            out_fad_s_reg  <= fad_s_next;
            out_fad_g_reg  <= fad_g_next;
        end
    end

    // Slot table memories
    always_ff @(posedge aclk) begin
        if (gen_we) begin
            gen_mem[wr_addr] <= gen_wd;
        end
        if (tag_we) begin
            tag_mem[wr_addr] <= tag_wd;
        end
        if (lc_we) begin
            lc_mem[wr_addr] <= lc_wd;
        end
        gen_rd_reg <= gen_mem[rd_addr];
        tag_rd_reg <= tag_mem[rd_addr];
        lc_rd_reg  <= lc_mem[rd_addr];
    end

    // Free stack memory
    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stk_mem[stk_wa] <= stk_wd;
        end
        if (stk_re) begin
            stk_rd_reg <= stk_mem[cnt_m1[SW-1:0]];
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_done_res          = out_done_reg;
    assign m_out_slot          = out_slot_reg;
    assign m_out_generation    = out_gen_reg;
    assign m_instance_out      = out_inst_reg;
    assign m_resolved_valid    = out_rvalid_reg;
    assign m_stale             = out_stale_reg;
    assign m_table_full        = out_full_reg;
    assign m_active_slot       = out_act_s_reg;
    assign m_active_generation = out_act_g_reg;
    assign m_fading_slot       = out_fad_s_reg;
    assign m_fading_generation = out_fad_g_reg;

endmodule

### rtl/generational_slot_registry.sv
// Generation-tagged slot allocator. Words enter a two-deep queue that classifies
// them; the back end reads the slot table (one read port, one write port) and the
// free stack, then writes back. An item steps through the back-end states IDLE,
// ISSUE and EXEC, with POP added for create (free stack read before the slot read)
// and WR2 for begin and end crossfade (second lifecycle write); the back end starts
// the next item only once the previous result word has been taken. After reset a
// clearing pass initializes the slot table and free stack; input words are queued
// meanwhile.
module generational_slot_registry #(
    parameter int SLOTS = 256,
    parameter int FADES = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [3:0]   s_op,
    input  logic [7:0]   s_handle_slot,
    input  logic [31:0]  s_handle_generation,
    input  logic [7:0]   s_other_slot,
    input  logic [31:0]  s_other_generation,
    input  logic [31:0]  s_fade_id,
    input  logic [31:0]  s_instance_tag,
    output logic         m_valid,
    input  logic         m_ready,
    output logic         m_done_res,
    output logic [7:0]   m_out_slot,
    output logic [31:0]  m_out_generation,
    output logic [31:0]  m_instance_out,
    output logic         m_resolved_valid,
    output logic         m_stale,
    output logic         m_table_full,
    output logic [7:0]   m_active_slot,
    output logic [31:0]  m_active_generation,
    output logic [7:0]   m_fading_slot,
    output logic [31:0]  m_fading_generation
);

    logic           q_valid;
    logic           q_pop;
    gsr_pkg::item_t q_item;

    gsr_front #(.SLOTS(SLOTS)) u_front (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_op                (s_op),
        .s_handle_slot       (s_handle_slot),
        .s_handle_generation (s_handle_generation),
        .s_other_slot        (s_other_slot),
        .s_other_generation  (s_other_generation),
        .s_fade_id           (s_fade_id),
        .s_instance_tag      (s_instance_tag),
        .q_valid             (q_valid),
        .q_item              (q_item),
        .q_pop               (q_pop)
    );

    gsr_exec #(.SLOTS(SLOTS), .FADES(FADES)) u_exec (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .q_valid             (q_valid),
        .q_item              (q_item),
        .q_pop               (q_pop),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_done_res          (m_done_res),
        .m_out_slot          (m_out_slot),
        .m_out_generation    (m_out_generation),
        .m_instance_out      (m_instance_out),
        .m_resolved_valid    (m_resolved_valid),
        .m_stale             (m_stale),
        .m_table_full        (m_table_full),
        .m_active_slot       (m_active_slot),
        .m_active_generation (m_active_generation),
        .m_fading_slot       (m_fading_slot),
        .m_fading_generation (m_fading_generation)
    );

endmodule
